@@ hdl/two_vector_xz_axis_rotation_map_assert.svh @@
// Assertion macros for the rotation map top module.
`ifndef TWO_VECTOR_XZ_AXIS_ROTATION_MAP_ASSERT_SVH
`define TWO_VECTOR_XZ_AXIS_ROTATION_MAP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define TVR_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define TVR_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

@@ hdl/tvr_pkg.sv @@
package tvr_pkg;

  localparam int unsigned InW  = 16;
  localparam int unsigned OutW = 16;
  localparam int unsigned AngW = 36;

  localparam logic signed [AngW-1:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [AngW-1:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [AngW-1:0] InvGain   = 36'sd652032874;
  localparam logic signed [17:0]     MapLimit  = 18'sd25736;

  typedef enum logic [1:0] {
    KindIdent = 2'd0,
    KindOpp   = 2'd1,
    KindGen   = 2'd2
  } kind_e;

  typedef enum logic {
    CfgParallel = 1'b0,
    CfgAxis     = 1'b1
  } cfg_idx_e;

  // Truncated arctangent table, Q.30 radians.
  function automatic logic signed [AngW-1:0] atan_tab(input logic [4:0] i);
    logic signed [AngW-1:0] r;
    case (i)
      5'd0:  r = 36'sh03243F6A8;
      5'd1:  r = 36'sh01DAC6705;
      5'd2:  r = 36'sh00FADBAFC;
      5'd3:  r = 36'sh007F56EA6;
      5'd4:  r = 36'sh003FEAB76;
      5'd5:  r = 36'sh001FFD55B;
      5'd6:  r = 36'sh000FFFAAA;
      5'd7:  r = 36'sh0007FFF55;
      5'd8:  r = 36'sh0003FFFEA;
      5'd9:  r = 36'sh0001FFFFD;
      5'd10: r = 36'sh0000FFFFF;
      5'd11: r = 36'sh00007FFFF;
      5'd12: r = 36'sh00003FFFF;
      5'd13: r = 36'sh00001FFFF;
      5'd14: r = 36'sh00000FFFF;
      5'd15: r = 36'sh000007FFF;
      5'd16: r = 36'sh000003FFF;
      5'd17: r = 36'sh000001FFF;
      5'd18: r = 36'sh000000FFF;
      5'd19: r = 36'sh0000007FF;
      5'd20: r = 36'sh0000003FF;
      5'd21: r = 36'sh0000001FF;
      5'd22: r = 36'sh0000000FF;
      5'd23: r = 36'sh00000007F;
      5'd24: r = 36'sh00000003F;
      5'd25: r = 36'sh00000001F;
      5'd26: r = 36'sh00000000F;
      5'd27: r = 36'sh000000008;
      5'd28: r = 36'sh000000004;
      5'd29: r = 36'sh000000002;
      5'd30: r = 36'sh000000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/tvr_vec_stage.sv @@
// Input alignment and exact cross/dot products, two register stages.
module tvr_vec_stage #(
  parameter int unsigned VECTOR_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic [6*VECTOR_BITS-1:0] raw_i,
  output logic                    vld_o,
  output logic signed [16:0]      rx_o, ry_o, rz_o, ox_o, oy_o, oz_o,
  output logic signed [33:0]      nx_o, ny_o, nz_o, ro_o
);

  function automatic logic signed [16:0] align(input logic [VECTOR_BITS-1:0] raw);
    logic signed [VECTOR_BITS+15:0] w;
    w = {{16{raw[VECTOR_BITS-1]}}, raw};
    if (VECTOR_BITS >= 16) begin
      w = w >>> (VECTOR_BITS - 16);
    end else begin
      w = w <<< (16 - VECTOR_BITS);
    end
    return w[16:0];
  endfunction

  logic signed [16:0] v_q [6];
  logic               vld1_q;
  logic signed [33:0] p_q [9];
  logic signed [16:0] r_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld_o  <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld_o  <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 6; k++) begin
        v_q[k] <= align(raw_i[k*VECTOR_BITS +: VECTOR_BITS]);
        r_q[k] <= v_q[k];
      end
      p_q[0] <= v_q[1] * v_q[5];
      p_q[1] <= v_q[2] * v_q[4];
      p_q[2] <= v_q[2] * v_q[3];
      p_q[3] <= v_q[0] * v_q[5];
      p_q[4] <= v_q[0] * v_q[4];
      p_q[5] <= v_q[1] * v_q[3];
      p_q[6] <= v_q[0] * v_q[3];
      p_q[7] <= v_q[1] * v_q[4];
      p_q[8] <= v_q[2] * v_q[5];
    end
  end

  assign rx_o = r_q[0];
  assign ry_o = r_q[1];
  assign rz_o = r_q[2];
  assign ox_o = r_q[3];
  assign oy_o = r_q[4];
  assign oz_o = r_q[5];
  assign nx_o = p_q[0] - p_q[1];
  assign ny_o = p_q[2] - p_q[3];
  assign nz_o = p_q[4] - p_q[5];
  assign ro_o = p_q[6] + p_q[7] + p_q[8];

endmodule

@@ hdl/tvr_cordic_step.sv @@
// One pipelined CORDIC iteration: vectoring (drive y to 0) or rotation
// (drive z to 0). Side data rides along with the item.
module tvr_cordic_step #(
  parameter int unsigned STEP  = 0,
  parameter bit          ROTATE = 1'b0,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  logic signed [tvr_pkg::AngW-1:0] x_i, y_i, z_i,
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     vld_o,
  output logic signed [tvr_pkg::AngW-1:0] x_o, y_o, z_o,
  output logic [SIDE_W-1:0]        side_o
);

  logic signed [tvr_pkg::AngW-1:0] dx, dy, at;
  logic up;

  assign dx = x_i >>> STEP;
  assign dy = y_i >>> STEP;
  assign at = tvr_pkg::atan_tab(5'(STEP));
  assign up = ROTATE ? (z_i >= 0) : (y_i < 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      if (up) begin
        x_o <= x_i - dy;
        y_o <= y_i + dx;
        z_o <= ROTATE ? z_i - at : z_i - at;
      end else begin
        x_o <= x_i + dy;
        y_o <= y_i - dx;
        z_o <= z_i + at;
      end
    end
  end

endmodule

@@ hdl/tvr_cordic.sv @@
// CORDIC_STEPS pipelined iterations with side data.
module tvr_cordic #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter bit          ROTATE = 1'b0,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  logic signed [tvr_pkg::AngW-1:0] x_i, y_i, z_i,
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     vld_o,
  output logic signed [tvr_pkg::AngW-1:0] x_o, y_o, z_o,
  output logic [SIDE_W-1:0]        side_o
);

  logic                            v [CORDIC_STEPS+1];
  logic signed [tvr_pkg::AngW-1:0] x [CORDIC_STEPS+1];
  logic signed [tvr_pkg::AngW-1:0] y [CORDIC_STEPS+1];
  logic signed [tvr_pkg::AngW-1:0] z [CORDIC_STEPS+1];
  logic [SIDE_W-1:0]               s [CORDIC_STEPS+1];

  assign v[0] = vld_i;
  assign x[0] = x_i;
  assign y[0] = y_i;
  assign z[0] = z_i;
  assign s[0] = side_i;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    tvr_cordic_step #(.STEP(g), .ROTATE(ROTATE), .SIDE_W(SIDE_W)) u_step (
      .clk_i, .rst_ni, .en_i,
      .vld_i(v[g]), .x_i(x[g]), .y_i(y[g]), .z_i(z[g]), .side_i(s[g]),
      .vld_o(v[g+1]), .x_o(x[g+1]), .y_o(y[g+1]), .z_o(z[g+1]), .side_o(s[g+1])
    );
  end

  assign vld_o  = v[CORDIC_STEPS];
  assign x_o    = x[CORDIC_STEPS];
  assign y_o    = y[CORDIC_STEPS];
  assign z_o    = z[CORDIC_STEPS];
  assign side_o = s[CORDIC_STEPS];

endmodule

@@ hdl/two_vector_xz_axis_rotation_map.sv @@
// Two-vector X-Z axis rotation map.
// Slave stream s_axis_*: one word per vector pair, tdata holds ref_x, ref_y,
// ref_z, off_x, off_y, off_z (16 bits each, low to high). Master stream
// m_axis_*: tdata holds map_x, map_z (Q3.13), tuser holds case_kind.
// Config channel cfg_*: index 0 is the parallel threshold, index 1 the axis
// threshold; write only while the block is idle. Reset loads 16 into both.
// The datapath is a pipeline: alignment and products, axis select, a CORDIC
// vectoring unit for the axis angle, a CORDIC rotation unit for the unit
// axis, the angle terms, a second vectoring unit for the rotation angle and
// the output scaling. One word is accepted every cycle while m_axis is not
// stalled. The whole pipeline advances only when its last stage is empty
// or being drained, so a stall on m_axis holds every stage and s_axis_tready
// falls; nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
module two_vector_xz_axis_rotation_map #(
  parameter int unsigned VECTOR_BITS  = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // ref_x, ref_y, ref_z, off_x, off_y, off_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // map_x, map_z
  output logic [1:0]  m_axis_tuser,   // case_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  `include "two_vector_xz_axis_rotation_map_assert.svh"

  localparam int unsigned AW = tvr_pkg::AngW;

  logic [15:0] par_thr_q, axis_thr_q;
  logic        en;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_thr_q  <= 16'd16;
      axis_thr_q <= 16'd16;
    end else if (cfg_valid) begin
      case (tvr_pkg::cfg_idx_e'(cfg_index))
        tvr_pkg::CfgParallel: par_thr_q  <= cfg_data;
        tvr_pkg::CfgAxis:     axis_thr_q <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Stage A: products.
  logic [6*VECTOR_BITS-1:0] raw;
  for (genvar g = 0; g < 6; g++) begin : g_raw
    assign raw[g*VECTOR_BITS +: VECTOR_BITS] =
        VECTOR_BITS'({{(VECTOR_BITS > 16 ? VECTOR_BITS-16 : 1){s_axis_tdata[g*16+15]}},
                      s_axis_tdata[g*16 +: 16]});
  end

  logic               va;
  logic signed [16:0] rx, ry, rz, ox, oy, oz;
  logic signed [33:0] nx, ny, nz, ro;

  tvr_vec_stage #(.VECTOR_BITS(VECTOR_BITS)) u_vec (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s_axis_tvalid), .raw_i(raw),
    .vld_o(va), .rx_o(rx), .ry_o(ry), .rz_o(rz), .ox_o(ox), .oy_o(oy), .oz_o(oz),
    .nx_o(nx), .ny_o(ny), .nz_o(nz), .ro_o(ro)
  );

  // Stage B: round cross product, candidate axes.
  function automatic logic signed [19:0] rnd15(input logic signed [33:0] v);
    logic signed [34:0] t;
    t = 35'(v) + 35'sd16384;
    return 20'(t >>> 15);
  endfunction

  logic               vb_q;
  logic signed [19:0] qx_q, qy_q, qz_q;
  logic signed [17:0] u1x_q, u1z_q, u2x_q, u2z_q, u3x_q, u3z_q;
  logic signed [16:0] brx_q, brz_q, box_q, boz_q;
  logic signed [33:0] bnx_q, bnz_q, bro_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (en) vb_q <= va;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_q <= rnd15(nx); qy_q <= rnd15(ny); qz_q <= rnd15(nz);
      u1x_q <= 18'(rz); u1z_q <= -18'(rx);
      u2x_q <= 18'(oz) - 18'(rz); u2z_q <= 18'(rx) - 18'(ox);
      u3x_q <= 18'(rx) + 18'(ox); u3z_q <= 18'(rz) + 18'(oz);
      brx_q <= rx; brz_q <= rz; box_q <= ox; boz_q <= oz;
      bnx_q <= nx; bnz_q <= nz; bro_q <= ro;
    end
  end

  // Stage C: squares.
  logic               vc_q;
  logic [41:0]        sq_q;
  logic [36:0]        l1_q, l2_q, l3_q;
  logic signed [17:0] cu1x_q, cu1z_q, cu2x_q, cu2z_q, cu3x_q, cu3z_q;
  logic signed [16:0] crx_q, crz_q, cox_q, coz_q;
  logic signed [33:0] cnx_q, cnz_q, cro_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else if (en) vc_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q <= 42'(qx_q * qx_q) + 42'(qy_q * qy_q) + 42'(qz_q * qz_q);
      l1_q <= 37'(u1x_q * u1x_q) + 37'(u1z_q * u1z_q);
      l2_q <= 37'(u2x_q * u2x_q) + 37'(u2z_q * u2z_q);
      l3_q <= 37'(u3x_q * u3x_q) + 37'(u3z_q * u3z_q);
      cu1x_q <= u1x_q; cu1z_q <= u1z_q; cu2x_q <= u2x_q; cu2z_q <= u2z_q;
      cu3x_q <= u3x_q; cu3z_q <= u3z_q;
      crx_q <= brx_q; crz_q <= brz_q; cox_q <= box_q; coz_q <= boz_q;
      cnx_q <= bnx_q; cnz_q <= bnz_q; cro_q <= bro_q;
    end
  end

  // Stage D: case decision and atan2 preprocessing.
  logic               par, l1ok, l2ok, l3ok, use_atan;
  logic signed [17:0] sux, suz;
  logic [1:0]         kind;

  assign par  = sq_q < 42'(par_thr_q);
  assign l1ok = l1_q >= 37'(axis_thr_q);
  assign l2ok = l2_q >= 37'(axis_thr_q);
  assign l3ok = l3_q >= 37'(axis_thr_q);

  always_comb begin
    sux = cu2x_q; suz = cu2z_q; use_atan = l2ok;
    kind = tvr_pkg::KindGen;
    if (par) begin
      kind = (cro_q >= 0) ? tvr_pkg::KindIdent : tvr_pkg::KindOpp;
      sux = cu1x_q; suz = cu1z_q; use_atan = (cro_q < 0) && l1ok;
    end else if (!l2ok) begin
      sux = cu3x_q; suz = cu3z_q; use_atan = l3ok;
    end
  end

  // Side data through the axis CORDICs.
  localparam int unsigned SW = 4 + 4*17 + 3*34;
  typedef struct packed {
    logic [1:0]         kind;
    logic               use_atan;
    logic               neg;
    logic signed [16:0] rx, rz, ox, oz;
    logic signed [33:0] nx, nz, ro;
  } side_t;

  logic                  vd_q;
  logic signed [AW-1:0]  dx_q, dy_q, dz_q;
  side_t                 sd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else if (en) vd_q <= vc_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q.kind <= kind; sd_q.use_atan <= use_atan; sd_q.neg <= 1'b0;
      sd_q.rx <= crx_q; sd_q.rz <= crz_q; sd_q.ox <= cox_q; sd_q.oz <= coz_q;
      sd_q.nx <= cnx_q; sd_q.nz <= cnz_q; sd_q.ro <= cro_q;
      if (sux < 0) begin
        dx_q <= -AW'(sux); dy_q <= -AW'(suz);
        dz_q <= (suz >= 0) ? tvr_pkg::PiQ30 : -tvr_pkg::PiQ30;
      end else begin
        dx_q <= AW'(sux); dy_q <= AW'(suz); dz_q <= '0;
      end
    end
  end

  logic                 ve;
  logic signed [AW-1:0] ex, ey, ez;
  side_t                se;
  tvr_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ROTATE(1'b0), .SIDE_W(SW)) u_vec1 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vd_q), .x_i(dx_q), .y_i(dy_q), .z_i(dz_q),
    .side_i(sd_q), .vld_o(ve), .x_o(ex), .y_o(ey), .z_o(ez), .side_o(se)
  );

  // Stage F: fold the angle into the right half-plane for rotation.
  logic                 vf_q;
  logic signed [AW-1:0] fz_q, fz_d;
  side_t                sf_q, sf_d;

  always_comb begin
    fz_d     = ez;
    sf_d     = se;
    sf_d.neg = 1'b0;
    // A zero input vector leaves x and y at zero; its angle is zero.
    if (ex == 0 && ey == 0) begin
      fz_d = '0;
    end else if (ez > tvr_pkg::HalfPiQ30) begin
      fz_d = ez - tvr_pkg::PiQ30; sf_d.neg = 1'b1;
    end else if (ez < -tvr_pkg::HalfPiQ30) begin
      fz_d = ez + tvr_pkg::PiQ30; sf_d.neg = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vf_q <= 1'b0;
    else if (en) vf_q <= ve;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sf_q <= sf_d;
      fz_q <= fz_d;
    end
  end

  logic                 vg;
  logic signed [AW-1:0] gx, gy, gz_unused;
  side_t                sg;
  tvr_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ROTATE(1'b1), .SIDE_W(SW)) u_rot (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vf_q), .x_i(tvr_pkg::InvGain), .y_i('0),
    .z_i(fz_q), .side_i(sf_q), .vld_o(vg), .x_o(gx), .y_o(gy), .z_o(gz_unused),
    .side_o(sg)
  );

  // Stage H: round to Q4.15 and pick the final axis.
  function automatic logic signed [18:0] rndq(input logic signed [AW-1:0] v);
    logic signed [AW:0] t;
    t = (AW+1)'(v) + (AW+1)'(16384);
    return 19'(t >>> 15);
  endfunction

  logic                 vh_q;
  logic signed [18:0]   ax_q, az_q;
  side_t                sh_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vh_q <= 1'b0;
    else if (en) vh_q <= vg;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sh_q <= sg;
      if (sg.kind == tvr_pkg::KindIdent) begin
        ax_q <= '0; az_q <= '0;
      end else if (!sg.use_atan) begin
        ax_q <= 19'sd32768; az_q <= '0;
      end else if (sg.neg) begin
        ax_q <= rndq(-gx); az_q <= rndq(-gy);
      end else begin
        ax_q <= rndq(gx); az_q <= rndq(gy);
      end
    end
  end

  // Stage I: projections and s product terms.
  logic                 vi_q;
  logic signed [36:0]   ar_q, ao_q;
  logic signed [54:0]   st_q;
  logic signed [18:0]   iax_q, iaz_q;
  logic [1:0]           ik_q;
  logic signed [33:0]   iro_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vi_q <= 1'b0;
    else if (en) vi_q <= vh_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ar_q <= 37'(ax_q * sh_q.rx) + 37'(az_q * sh_q.rz);
      ao_q <= 37'(ax_q * sh_q.ox) + 37'(az_q * sh_q.oz);
      st_q <= 55'(sh_q.nx * ax_q) + 55'(sh_q.nz * az_q);
      iax_q <= ax_q; iaz_q <= az_q; ik_q <= sh_q.kind; iro_q <= sh_q.ro;
    end
  end

  // Stage J: d and s.
  logic                 vj_q;
  logic signed [AW-1:0] jd_q, js_q;
  logic signed [73:0]   pp;
  logic signed [AW+4:0] rtmp;
  logic signed [55:0]   stmp;
  assign pp   = 74'(ar_q) * 74'(ao_q);
  assign rtmp = (AW+5)'((pp + 74'sd536870912) >>> 30);
  assign stmp = (56'(st_q) + 56'sd16384) >>> 15;

  typedef struct packed {
    logic signed [18:0] ax, az;
    logic [1:0]         kind;
  } ang_side_t;
  ang_side_t js_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vj_q <= 1'b0;
    else if (en) vj_q <= vi_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      js_side_q <= '{ax: iax_q, az: iaz_q, kind: ik_q};
      if (ik_q == tvr_pkg::KindGen) begin
        jd_q <= AW'(36'(iro_q) - 36'(rtmp));
        js_q <= AW'(stmp);
      end else begin
        // Parallel words need no angle search; stage M sets their angle.
        jd_q <= '0;
        js_q <= '0;
      end
    end
  end

  // Stage K: atan2 preprocessing for the rotation angle.
  logic                 vk_q;
  logic signed [AW-1:0] kx_q, ky_q, kz_q;
  ang_side_t            ks_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vk_q <= 1'b0;
    else if (en) vk_q <= vj_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ks_q <= js_side_q;
      if (jd_q < 0) begin
        kx_q <= -jd_q; ky_q <= -js_q;
        kz_q <= (js_q >= 0) ? tvr_pkg::PiQ30 : -tvr_pkg::PiQ30;
      end else begin
        kx_q <= jd_q; ky_q <= js_q; kz_q <= '0;
      end
    end
  end

  logic                 vl;
  logic signed [AW-1:0] lx, ly, lz;
  ang_side_t            ls;
  tvr_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ROTATE(1'b0), .SIDE_W(40)) u_vec2 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vk_q), .x_i(kx_q), .y_i(ky_q), .z_i(kz_q),
    .side_i(ks_q), .vld_o(vl), .x_o(lx), .y_o(ly), .z_o(lz), .side_o(ls)
  );

  // Stage M: products with the angle. Opposite vectors turn by exactly pi,
  // and a zero vector into the CORDIC gives angle zero.
  logic                 vm_q;
  logic signed [55:0]   mx_q, mz_q;
  logic [1:0]           mk_q;
  logic signed [AW-1:0] ang;
  assign ang = (ls.kind == tvr_pkg::KindOpp) ? tvr_pkg::PiQ30 :
               ((lx == 0 && ly == 0) ? '0 : lz);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm_q <= 1'b0;
    else if (en) vm_q <= vl;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q <= 56'(ls.ax * ang);
      mz_q <= 56'(ls.az * ang);
      mk_q <= ls.kind;
    end
  end

  // Stage N: round and saturate into the output register.
  function automatic logic [15:0] sat(input logic signed [55:0] p);
    logic signed [55:0] v;
    v = (p + 56'sh80000000) >>> 32;
    if (v > 56'(tvr_pkg::MapLimit)) v = 56'(tvr_pkg::MapLimit);
    if (v < -56'(tvr_pkg::MapLimit)) v = -56'(tvr_pkg::MapLimit);
    return v[15:0];
  endfunction

  logic vn_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vn_q <= 1'b0;
    else if (en) vn_q <= vm_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= {sat(mz_q), sat(mx_q)};
      m_axis_tuser <= mk_q;
    end
  end
  assign m_axis_tvalid = vn_q;

  `TVR_ASSERT_IMPL(a_stall_no_accept, clk_i, rst_ni,
                   m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `TVR_ASSERT_NEXT(a_out_holds, clk_i, rst_ni,
                   m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `TVR_ASSERT_IMPL(a_kind_legal, clk_i, rst_ni, m_axis_tvalid,
                   m_axis_tuser == tvr_pkg::KindIdent || m_axis_tuser == tvr_pkg::KindOpp ||
                   m_axis_tuser == tvr_pkg::KindGen)

endmodule
